@@ design/btfp_pkg.sv @@
// ---------------------------------------------------------------------------
// btfp_pkg
// Types, codes and keyword tables shared by the boolean text field parser.
// ---------------------------------------------------------------------------
package btfp_pkg;

   // longest custom string or keyword that can match
   localparam int unsigned MAX_TEXT_BYTES = 8;
   localparam int unsigned KW_COUNT       = 16;
   localparam int unsigned CSR_IDX_W      = 3;
   localparam int unsigned CSR_DATA_W     = 64;

   // keywords that stand for true: 1 t true y yes on enable enabled
   localparam logic [KW_COUNT-1:0] KW_TRUE_SET = 16'h34CD;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_END_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_SEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUE_TEXT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUE_LENGTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALSE_TEXT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FALSE_LENGTH = 3'd5;

   // terminator modes
   localparam logic [2:0] MODE_TAB_LF    = 3'd0;
   localparam logic [2:0] MODE_TAB_LF_CR = 3'd1;
   localparam logic [2:0] MODE_SEP_LF_CR = 3'd2;
   localparam logic [2:0] MODE_END_ONLY  = 3'd3;
   localparam logic [2:0] MODE_QUOTE     = 3'd4;

   // result status
   localparam logic [1:0] ST_PARSED    = 2'd0;
   localparam logic [1:0] ST_NOT_BOOL  = 2'd1;
   localparam logic [1:0] ST_END_EMPTY = 2'd2;

   // which matcher hit
   localparam logic [1:0] MB_TRUE    = 2'd0;
   localparam logic [1:0] MB_FALSE   = 2'd1;
   localparam logic [1:0] MB_KEYWORD = 2'd2;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   // reset values of the configuration registers
   localparam logic [2:0]  RST_END_MODE     = MODE_TAB_LF;
   localparam logic [7:0]  RST_FIELD_SEP    = 8'h2C;
   localparam logic [63:0] RST_TRUE_TEXT    = 64'h0000_0000_6575_7274;
   localparam logic [3:0]  RST_TRUE_LENGTH  = 4'd4;
   localparam logic [63:0] RST_FALSE_TEXT   = 64'h0000_0065_736C_6166;
   localparam logic [3:0]  RST_FALSE_LENGTH = 4'd5;

   typedef struct packed {
      logic [2:0]  end_mode;
      logic [7:0]  field_separator;
      logic [63:0] true_text;
      logic [3:0]  true_length;
      logic [63:0] false_text;
      logic [3:0]  false_length;
   } cfg_type;

   typedef struct packed {
      logic [3:0]          field_length;
      logic                true_match;
      logic                false_match;
      logic [KW_COUNT-1:0] kw_cand;
   } field_state_type;

   typedef struct packed {
      logic       bool_value;
      logic [1:0] parse_status;
      logic [1:0] matched_by;
   } result_type;

   localparam field_state_type FIELD_CLEAR = '{
      field_length: 4'd0,
      true_match:   1'b1,
      false_match:  1'b1,
      kw_cand:      {KW_COUNT{1'b1}}
   };

   // keyword text, first character in the low byte
   function automatic logic [63:0] kw_text(input logic [3:0] k);
      logic [63:0] t;
      case (k)
         4'd0:    t = 64'h31;
         4'd1:    t = 64'h30;
         4'd2:    t = 64'h74;
         4'd3:    t = 64'h6575_7274;
         4'd4:    t = 64'h66;
         4'd5:    t = 64'h65_736C_6166;
         4'd6:    t = 64'h79;
         4'd7:    t = 64'h73_6579;
         4'd8:    t = 64'h6E;
         4'd9:    t = 64'h6F6E;
         4'd10:   t = 64'h6E6F;
         4'd11:   t = 64'h66_666F;
         4'd12:   t = 64'h656C_6261_6E65;
         4'd13:   t = 64'h64_656C_6261_6E65;
         4'd14:   t = 64'h65_6C62_6173_6964;
         default: t = 64'h6465_6C62_6173_6964;
      endcase
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input logic [3:0] k);
      logic [3:0] n;
      case (k)
         4'd3:                    n = 4'd4;
         4'd5:                    n = 4'd5;
         4'd7, 4'd11:             n = 4'd3;
         4'd9, 4'd10:             n = 4'd2;
         4'd12:                   n = 4'd6;
         4'd13, 4'd14:            n = 4'd7;
         4'd15:                   n = 4'd8;
         default:                 n = 4'd1;
      endcase
      return n;
   endfunction

endpackage

@@ design/boolean_text_field_parser_unit.sv @@
// ---------------------------------------------------------------------------
// boolean_text_field_parser_unit
// Parses delimited text fields to booleans, a byte per cycle unless stalled.
// ---------------------------------------------------------------------------
// Text bytes enter on the req_ channel (req_valid / req_stall), one byte or
// an end-of-input marker per transfer. Each terminator byte or end-of-input
// closes the current field and yields one transfer on the rsp_ channel with
// the value, a status and the matcher that hit; other bytes yield nothing.
// A byte is taken into an input register; when that register moves on, the
// byte's field update is done and any result is placed in the output
// register, from which it shows on rsp_valid.
// Throughput is one byte per cycle: the input register drains every cycle
// unless it holds a closing byte while the output register is full and
// stalled, and only then is req_stall raised.
// The user writes configuration on the csr_ port only while idle (unchecked).
// Synchronous reset restores the register defaults (tab/LF terminators,
// custom strings "true" and "false"), clears the field state and empties
// both registers. A stalled result holds its value until taken.
// ---------------------------------------------------------------------------
module boolean_text_field_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_text_byte,
   input  logic                                 req_end_of_input,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_bool_value,
   output logic [1:0]                           rsp_parse_status,
   output logic [1:0]                           rsp_matched_by,
   input  logic                                 csr_write_enable,
   input  logic [btfp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [btfp_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   btfp_pkg::cfg_type         cfg_ff, cfg_in;
   btfp_pkg::field_state_type field_ff, field_in, field_next;
   btfp_pkg::result_type      out_ff, out_in, close_res;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_eoi_ff, in_eoi_in;
   logic       out_valid_ff, out_valid_in;
   logic       has_result;
   logic       s1_advance;
   logic       req_take;

   btfp_match u_match (
      .cfg          (cfg_ff),
      .cur          (field_ff),
      .text_byte    (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .nxt          (field_next),
      .has_result   (has_result),
      .result       (close_res)
   );

   // the input stage moves on unless its result cannot be placed
   assign s1_advance = in_valid_ff && (!has_result || !out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            btfp_pkg::CSR_END_MODE:     cfg_in.end_mode        = csr_write_data[2:0];
            btfp_pkg::CSR_FIELD_SEP:    cfg_in.field_separator = csr_write_data[7:0];
            btfp_pkg::CSR_TRUE_TEXT:    cfg_in.true_text       = csr_write_data;
            btfp_pkg::CSR_TRUE_LENGTH:  cfg_in.true_length     = csr_write_data[3:0];
            btfp_pkg::CSR_FALSE_TEXT:   cfg_in.false_text      = csr_write_data;
            btfp_pkg::CSR_FALSE_LENGTH: cfg_in.false_length    = csr_write_data[3:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff && !s1_advance;
      in_byte_in  = in_byte_ff;
      in_eoi_in   = in_eoi_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
         in_eoi_in   = req_end_of_input;
      end
   end

   assign field_in = s1_advance ? field_next : field_ff;

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      if (s1_advance && has_result) begin
         out_valid_in = 1'b1;
         out_in       = close_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.end_mode        <= btfp_pkg::RST_END_MODE;
         cfg_ff.field_separator <= btfp_pkg::RST_FIELD_SEP;
         cfg_ff.true_text       <= btfp_pkg::RST_TRUE_TEXT;
         cfg_ff.true_length     <= btfp_pkg::RST_TRUE_LENGTH;
         cfg_ff.false_text      <= btfp_pkg::RST_FALSE_TEXT;
         cfg_ff.false_length    <= btfp_pkg::RST_FALSE_LENGTH;
         field_ff               <= btfp_pkg::FIELD_CLEAR;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         field_ff     <= field_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eoi_ff  <= in_eoi_in;
      out_ff     <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_bool_value   = out_ff.bool_value;
   assign rsp_parse_status = out_ff.parse_status;
   assign rsp_matched_by   = out_ff.matched_by;

endmodule

@@ design/btfp_match.sv @@
// ---------------------------------------------------------------------------
// btfp_match
// Per-byte field update and close evaluation of the boolean parser.
// ---------------------------------------------------------------------------
module btfp_match (
   input  btfp_pkg::cfg_type         cfg,
   input  btfp_pkg::field_state_type cur,
   input  logic [7:0]                text_byte,
   input  logic                      end_of_input,
   output btfp_pkg::field_state_type nxt,
   output logic                      has_result,
   output btfp_pkg::result_type      result
);

   localparam logic [3:0] MAX_LEN = 4'(btfp_pkg::MAX_TEXT_BYTES);

   logic                      is_term;
   logic [7:0]                lc;
   logic [2:0]                pos;
   logic                      pos_ok;
   btfp_pkg::result_type      close_res;
   btfp_pkg::field_state_type absorbed;
   logic [63:0]               kt;

   always_comb begin
      case (cfg.end_mode)
         btfp_pkg::MODE_TAB_LF:
            is_term = (text_byte == btfp_pkg::CH_TAB) || (text_byte == btfp_pkg::CH_LF);
         btfp_pkg::MODE_TAB_LF_CR:
            is_term = (text_byte == btfp_pkg::CH_TAB) || (text_byte == btfp_pkg::CH_LF) ||
                      (text_byte == btfp_pkg::CH_CR);
         btfp_pkg::MODE_SEP_LF_CR:
            is_term = (text_byte == cfg.field_separator) || (text_byte == btfp_pkg::CH_LF) ||
                      (text_byte == btfp_pkg::CH_CR);
         btfp_pkg::MODE_QUOTE:
            is_term = (text_byte == btfp_pkg::CH_QUOTE);
         default:
            is_term = 1'b0;
      endcase
   end

   assign lc     = (text_byte >= btfp_pkg::CH_UP_A && text_byte <= btfp_pkg::CH_UP_Z) ?
                   text_byte + btfp_pkg::CASE_OFS : text_byte;
   assign pos    = cur.field_length[2:0];
   assign pos_ok = cur.field_length < MAX_LEN;

   // matcher update for a byte that stays in the field
   always_comb begin
      absorbed = cur;
      absorbed.true_match  = cur.true_match && (cur.field_length < cfg.true_length) &&
                             pos_ok && (text_byte == cfg.true_text[8*pos +: 8]);
      absorbed.false_match = cur.false_match && (cur.field_length < cfg.false_length) &&
                             pos_ok && (text_byte == cfg.false_text[8*pos +: 8]);
      kt = '0;
      for (int k = 0; k < int'(btfp_pkg::KW_COUNT); k++) begin
         kt = btfp_pkg::kw_text(4'(k));
         if (!((cur.field_length < btfp_pkg::kw_len(4'(k))) && (lc == kt[8*pos +: 8]))) begin
            absorbed.kw_cand[k] = 1'b0;
         end
      end
      if (cur.field_length != 4'hF) begin
         absorbed.field_length = cur.field_length + 4'd1;
      end
   end

   // close evaluation, priority true, false, keyword
   always_comb begin
      close_res = '{bool_value: 1'b0, parse_status: btfp_pkg::ST_NOT_BOOL,
                    matched_by: btfp_pkg::MB_TRUE};
      for (int k = int'(btfp_pkg::KW_COUNT) - 1; k >= 0; k--) begin
         if (cur.kw_cand[k] && (btfp_pkg::kw_len(4'(k)) == cur.field_length)) begin
            close_res.bool_value   = btfp_pkg::KW_TRUE_SET[k];
            close_res.parse_status = btfp_pkg::ST_PARSED;
            close_res.matched_by   = btfp_pkg::MB_KEYWORD;
         end
      end
      if (cur.false_match && (cfg.false_length <= MAX_LEN) &&
          (cur.field_length == cfg.false_length)) begin
         close_res = '{bool_value: 1'b0, parse_status: btfp_pkg::ST_PARSED,
                       matched_by: btfp_pkg::MB_FALSE};
      end
      if (cur.true_match && (cfg.true_length <= MAX_LEN) &&
          (cur.field_length == cfg.true_length)) begin
         close_res = '{bool_value: 1'b1, parse_status: btfp_pkg::ST_PARSED,
                       matched_by: btfp_pkg::MB_TRUE};
      end
   end

   always_comb begin
      nxt        = absorbed;
      has_result = 1'b0;
      result     = close_res;
      if (end_of_input) begin
         nxt        = btfp_pkg::FIELD_CLEAR;
         has_result = 1'b1;
         if (cur.field_length == 4'd0) begin
            result = '{bool_value: 1'b0, parse_status: btfp_pkg::ST_END_EMPTY,
                       matched_by: btfp_pkg::MB_TRUE};
         end else if (cfg.end_mode == btfp_pkg::MODE_QUOTE) begin
            // only a quote closes a value in quote mode
            result = '{bool_value: 1'b0, parse_status: btfp_pkg::ST_NOT_BOOL,
                       matched_by: btfp_pkg::MB_TRUE};
         end
      end else if (is_term) begin
         nxt        = btfp_pkg::FIELD_CLEAR;
         has_result = 1'b1;
      end
   end

endmodule
